>>> hdl/tagged_lifo_stack_top_defines.svh
// Assertion macros for the tagged LIFO stack.
// Used by tagged_lifo_stack_top; expects i_clk and i_rst_n in scope.
`ifndef TAGGED_LIFO_STACK_TOP_DEFINES_SVH
`define TAGGED_LIFO_STACK_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define TLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is held
`define TLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tls_pkg.sv
// Shared types, codes and constants for the tagged LIFO stack.
// No dependencies; imported by tls_tag_unit, tagged_lifo_stack_top and the bench.
package tls_pkg;

    localparam int unsigned NODE_COUNT = 256;
    localparam int unsigned ADDR_W     = $clog2(NODE_COUNT);
    localparam int unsigned NODE_W     = 8;
    localparam int unsigned TAG_W      = 16;
    localparam int unsigned GEN_W      = 64;

    localparam int unsigned XS_SHIFT_A = 12;
    localparam int unsigned XS_SHIFT_B = 25;
    localparam int unsigned XS_SHIFT_C = 27;
    localparam logic [63:0] XS_MULT    = 64'h2545_F491_4F6C_DD1D;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_NULL  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [GEN_W-1:0] state;
    } t_tag_req;

    typedef struct packed {
        logic             done;
        logic [TAG_W-1:0] tag;
    } t_tag_rsp;

    // xorshift64 state update
    function automatic logic [GEN_W-1:0] xs_step(input logic [GEN_W-1:0] s);
        logic [GEN_W-1:0] t;
        t = s ^ (s >> XS_SHIFT_A);
        t = t ^ (t << XS_SHIFT_B);
        t = t ^ (t >> XS_SHIFT_C);
        return t;
    endfunction

endpackage

>>> hdl/tls_tag_unit.sv
// Tag generator: top 16 bits of (state * XS_MULT) mod 2^64.
// One shared 32x32 multiplier over three phases; depends on tls_pkg.
module tls_tag_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tls_pkg::t_tag_req i_req,
    output tls_pkg::t_tag_rsp o_rsp
);
    import tls_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_LL   = 3'd1;
    localparam logic [2:0] PH_HL   = 3'd2;
    localparam logic [2:0] PH_LH   = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [63:0] r_s;
    logic [63:0] r_p0;
    logic [31:0] r_p1, r_p2;
    logic [31:0] w_a, w_b;
    logic [63:0] w_prod;
    logic [31:0] w_hi;

    // operand select for the shared multiplier
    always_comb begin
        w_a = r_s[31:0];
        w_b = XS_MULT[31:0];
        case (r_phase)
            PH_HL: begin
                w_a = r_s[63:32];
            end
            PH_LH: begin
                w_b = XS_MULT[63:32];
            end
            default: begin
                w_a = r_s[31:0];
            end
        endcase
    end

    assign w_prod = {32'd0, w_a} * {32'd0, w_b};

    always_comb begin
        case (r_phase)
            PH_IDLE: n_phase = i_req.start ? PH_LL : PH_IDLE;
            PH_LL:   n_phase = PH_HL;
            PH_HL:   n_phase = PH_LH;
            PH_LH:   n_phase = PH_SUM;
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == PH_IDLE && i_req.start) begin
            r_s <= i_req.state;
        end
        case (r_phase)
            PH_LL:   r_p0 <= w_prod;
            PH_HL:   r_p1 <= w_prod[31:0];
            PH_LH:   r_p2 <= w_prod[31:0];
            default: ;
        endcase
    end

    // cross terms only reach bits 63:32; low half carries nothing upward
    assign w_hi       = r_p0[63:32] + r_p1 + r_p2;
    assign o_rsp.done = (r_phase == PH_SUM);
    assign o_rsp.tag  = w_hi[31:16];

endmodule

>>> hdl/tagged_lifo_stack_top.sv
// Top level of the tagged LIFO stack: head, generator, link memory, sequencer.
// Depends on tls_pkg, tls_tag_unit and tagged_lifo_stack_top_defines.svh.
//
//  channel   ports                                      handshake
//  --------  -----------------------------------------  ----------------------
//  command   i_operation, i_node                        start & !busy
//  result    o_status, o_popped_node, o_head_node,      o_done, one cycle,
//            o_head_tag                                 cannot be held off
//  config    i_seed_wdata                               i_seed_we
//
// A successful push or pop steps from accept through the tag unit's LL, HL, LH and
// SUM phases to the registered result strobe; busy is high while the sequencer is in
// ST_TAG, and the pop's link read overlaps the multiply. A rejected push or an empty
// pop answers in the next cycle. Reset (synchronous, active low) empties the stack
// and loads the generator with 1; the link memory is not cleared. The result side
// cannot stall; a new command may be taken in the cycle its predecessor's result is
// shown.
module tagged_lifo_stack_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_operation,
    input  logic [tls_pkg::NODE_W-1:0] i_node,
    input  logic                       i_seed_we,
    input  logic [tls_pkg::GEN_W-1:0]  i_seed_wdata,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic [tls_pkg::NODE_W-1:0] o_popped_node,
    output logic [tls_pkg::NODE_W-1:0] o_head_node,
    output logic [tls_pkg::TAG_W-1:0]  o_head_tag
);
    import tls_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TAG  = 1'b1;

    logic              r_state;
    logic              r_pop_pend;
    logic [NODE_W-1:0] r_top;
    logic [TAG_W-1:0]  r_top_tag;
    logic [GEN_W-1:0]  r_gen;

    // link memory, one write or one read per cycle
    logic [NODE_W-1:0] r_link [NODE_COUNT];
    logic [NODE_W-1:0] r_rdata;

    logic     w_accept;
    logic     w_push_ok;
    logic     w_pop_ok;
    logic     w_reject;
    t_tag_req w_tag_req;
    t_tag_rsp w_tag_rsp;

    logic              r_done;
    logic [1:0]        r_status;
    logic [NODE_W-1:0] r_popped;
    logic [NODE_W-1:0] r_out_head;
    logic [TAG_W-1:0]  r_out_tag;

    assign busy      = (r_state != ST_IDLE);
    assign w_accept  = start && !busy;
    assign w_push_ok = w_accept && (i_operation == OP_PUSH) && (i_node != '0)
                       && (32'(i_node) < NODE_COUNT);
    assign w_pop_ok  = w_accept && (i_operation == OP_POP) && (r_top != '0);
    assign w_reject  = w_accept && !w_push_ok && !w_pop_ok;

    assign w_tag_req.start = w_push_ok || w_pop_ok;
    assign w_tag_req.state = xs_step(r_gen);

    tls_tag_unit u_tag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tag_req),
        .o_rsp   (w_tag_rsp)
    );

    // push writes the old head as the node's link; pop reads the head's link
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_link[ADDR_W'(i_node)] <= r_top;
        end
        if (w_pop_ok) begin
            r_rdata <= r_link[ADDR_W'(r_top)];
        end
    end

    // sequencer and head state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pop_pend <= 1'b0;
            r_top      <= '0;
            r_top_tag  <= '0;
            r_gen      <= GEN_W'(1);
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_push_ok || w_pop_ok) begin
                        r_state    <= ST_TAG;
                        r_pop_pend <= w_pop_ok;
                        r_gen      <= w_tag_req.state;
                        if (w_push_ok) begin
                            r_top <= i_node;
                        end
                    end
                end
                ST_TAG: begin
                    // link data is in r_rdata in the cycle after the pop's read
                    if (r_pop_pend) begin
                        r_top      <= r_rdata;
                        r_pop_pend <= 1'b0;
                    end
                    if (w_tag_rsp.done) begin
                        r_top_tag <= w_tag_rsp.tag;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // reseed: empty the stack, load the generator
            if (i_seed_we) begin
                r_gen     <= i_seed_wdata;
                r_top     <= '0;
                r_top_tag <= '0;
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_reject || (r_state == ST_TAG && w_tag_rsp.done);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_reject) begin
            r_status   <= (i_operation == OP_POP) ? STAT_EMPTY : STAT_NULL;
            r_popped   <= '0;
            r_out_head <= r_top;
            r_out_tag  <= r_top_tag;
        end else if (w_pop_ok) begin
            r_status <= STAT_OK;
            r_popped <= r_top;
        end else if (w_push_ok) begin
            r_status <= STAT_OK;
            r_popped <= '0;
        end
        if (r_state == ST_TAG && w_tag_rsp.done) begin
            r_out_head <= r_top;
            r_out_tag  <= w_tag_rsp.tag;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_popped_node = r_popped;
    assign o_head_node   = r_out_head;
    assign o_head_tag    = r_out_tag;

`include "tagged_lifo_stack_top_defines.svh"

    `TLS_ASSERT_NEXT(a_ok_goes_busy, w_push_ok || w_pop_ok, busy,
        "successful push or pop did not start the tag sequence")
    `TLS_ASSERT_NOW(a_tag_done_in_seq, w_tag_rsp.done, r_state == ST_TAG,
        "tag unit finished outside the tag sequence")
    `TLS_ASSERT_NEXT(a_reject_answers, w_reject, o_done && !busy,
        "rejected transaction did not answer in the next cycle")
    `TLS_ASSERT_NOW(a_empty_fields, o_done && o_status == STAT_EMPTY,
        o_popped_node == '0 && o_head_node == '0,
        "empty pop reported a node")

endmodule

>>> bench/tb_tagged_lifo_stack_top.sv
// Self-checking bench for tagged_lifo_stack_top: a directed table, then random push/pop traffic.
// Depends on tls_pkg and tagged_lifo_stack_top; a local model of the stack and the
// xorshift64* tag generator predicts every result the directed table does not give.
module tb_tagged_lifo_stack_top;
    import tls_pkg::*;

    localparam int unsigned SETTLE_CYCLES  = 8;    // outlasts a whole push/pop sequence
    localparam int unsigned WATCHDOG_LIMIT = 500;  // cycles with no transaction at all
    localparam int unsigned PHASE_ITEMS    = 275;  // six random phases, ~1650 commands
    localparam int unsigned IDLE_PCT       = 17;

    // one result transaction as the block reports it
    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] popped;
        logic [NODE_W-1:0] head;
        logic [TAG_W-1:0]  tag;
    } t_stack_result;

    typedef enum bit {ROW_CMD, ROW_SEED} t_row_kind;

    // directed table row; st/popped/head/tag are used only when typed is set
    typedef struct {
        t_row_kind         kind;
        logic              op;
        logic [NODE_W-1:0] nd;
        logic [GEN_W-1:0]  seed;
        bit                typed;
        logic [1:0]        st;
        logic [NODE_W-1:0] popped;
        logic [NODE_W-1:0] head;
        logic [TAG_W-1:0]  tag;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_operation;
    logic [NODE_W-1:0]  i_node;
    logic               i_seed_we;
    logic [GEN_W-1:0]   i_seed_wdata;
    logic               o_done;
    logic [1:0]         o_status;
    logic [NODE_W-1:0]  o_popped_node;
    logic [NODE_W-1:0]  o_head_node;
    logic [TAG_W-1:0]   o_head_tag;

    // model state: head pointer, tag, generator, next-link table
    logic [NODE_W-1:0]  stk_top = '0;
    logic [TAG_W-1:0]   stk_tag = '0;
    logic [GEN_W-1:0]   gen_state = 64'd1;
    logic [NODE_W-1:0]  link_mem [NODE_COUNT];
    bit                 on_stack [NODE_COUNT];   // stimulus hint only, not used for checking

    t_stack_result      pending_results [$];
    t_row               plan [$];

    bit                 idle_on = 1'b1;
    int unsigned        mismatches = 0;
    int unsigned        n_checked = 0;
    int unsigned        n_push_ok = 0;
    int unsigned        n_pop_ok = 0;
    int unsigned        n_null = 0;
    int unsigned        n_empty = 0;
    int unsigned        n_seed = 0;
    int unsigned        quiet_cycles = 0;

    tagged_lifo_stack_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_node        (i_node),
        .i_seed_we     (i_seed_we),
        .i_seed_wdata  (i_seed_wdata),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_popped_node (o_popped_node),
        .o_head_node   (o_head_node),
        .o_head_tag    (o_head_tag)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // xorshift64* step: new state, tag is the top 16 bits of state * multiplier
    function automatic logic [TAG_W-1:0] next_head_tag();
        logic [GEN_W-1:0] s;
        logic [GEN_W-1:0] prod;
        s = gen_state;
        s = s ^ (s >> XS_SHIFT_A);
        s = s ^ (s << XS_SHIFT_B);
        s = s ^ (s >> XS_SHIFT_C);
        gen_state = s;
        prod = s * XS_MULT;
        return prod[GEN_W-1 -: TAG_W];
    endfunction

    // push links the node to the old head; pop follows the head's link.
    // A null push and a pop on an empty stack leave everything alone.
    function automatic t_stack_result apply_stack_op(input logic op, input logic [NODE_W-1:0] nd);
        t_stack_result r;
        r.status = STAT_OK;
        r.popped = '0;
        if (op == OP_PUSH) begin
            if (nd == '0) begin
                r.status = STAT_NULL;
            end else begin
                link_mem[nd] = stk_top;   // re-pushing a live node corrupts the list, as intended
                stk_top = nd;
                stk_tag = next_head_tag();
            end
        end else if (stk_top == '0) begin
            r.status = STAT_EMPTY;
        end else begin
            r.popped = stk_top;
            stk_top = link_mem[stk_top];
            stk_tag = next_head_tag();
        end
        r.head = stk_top;
        r.tag = stk_tag;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [GEN_W-1:0] got,
                                   input logic [GEN_W-1:0] want);
        $display("MISMATCH @%0t %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Present one command and hold it until the block takes it (start & !busy at an edge).
    // Returns the predicted result; the caller queues it. Random idle gaps go in front.
    task automatic issue_cmd(input logic op, input logic [NODE_W-1:0] nd,
                             output t_stack_result r);
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            start <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_node <= nd;
        do @(posedge i_clk); while (busy);
        r = apply_stack_op(op, nd);
        case (r.status)
            STAT_NULL:  n_null++;
            STAT_EMPTY: n_empty++;
            default: begin
                if (op == OP_PUSH) begin
                    n_push_ok++;
                    on_stack[nd] = 1'b1;
                end else begin
                    n_pop_ok++;
                    on_stack[r.popped] = 1'b0;
                end
            end
        endcase
    endtask

    // drop start, drain outstanding results, let the block settle
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // seed load only while idle; it also empties the stack
    task automatic load_seed(input logic [GEN_W-1:0] v);
        drain_results();
        i_seed_we <= 1'b1;
        i_seed_wdata <= v;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        gen_state = v;
        stk_top = '0;
        stk_tag = '0;
        foreach (on_stack[k]) on_stack[k] = 1'b0;
        n_seed++;
    endtask

    // ------------------------------------------------------------------
    // Result side: the block cannot be held off, so every o_done cycle is
    // one transaction, compared against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_stack_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing outstanding", GEN_W'(o_status), '0);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_status !== want.status)
                    report_mismatch("status", GEN_W'(o_status), GEN_W'(want.status));
                if (o_popped_node !== want.popped)
                    report_mismatch("popped_node", GEN_W'(o_popped_node),
                                    GEN_W'(want.popped));
                if (o_head_node !== want.head)
                    report_mismatch("head_node", GEN_W'(o_head_node), GEN_W'(want.head));
                if (o_head_tag !== want.tag)
                    report_mismatch("head_tag", GEN_W'(o_head_tag), GEN_W'(want.tag));
            end
        end
    end

    // Watchdog: any command, result or seed write counts as progress.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_done || i_seed_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_stack_result r;
        logic          op;
        logic [NODE_W-1:0] nd;
        logic [GEN_W-1:0]  seed_v;
        int unsigned   push_pct;
        int unsigned   tries;

        foreach (link_mem[k]) link_mem[k] = '0;
        foreach (on_stack[k]) on_stack[k] = 1'b0;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_operation <= OP_PUSH;
        i_node <= '0;
        i_seed_we <= 1'b0;
        i_seed_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed table ----
        // Out of reset (seed 1, empty stack): empty pop, null push, a few pushes/pops
        // with extreme node numbers, a double push that loops the list on itself.
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b1, STAT_EMPTY, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd0, 64'd0, 1'b1, STAT_NULL, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd255, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd1, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd128, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd127, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd7, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd7, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        // zero seed: generator sticks at zero, every tag is 0, so results are known
        plan.push_back('{ROW_SEED, OP_PUSH, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b1, STAT_EMPTY, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd9, 64'd0, 1'b1, STAT_OK, 8'd0, 8'd9, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd200, 64'd0, 1'b1, STAT_OK, 8'd0, 8'd200, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b1, STAT_OK, 8'd200, 8'd9, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd0, 64'd0, 1'b1, STAT_NULL, 8'd0, 8'd9, 16'd0});
        // all-ones and top-bit-only seeds
        plan.push_back('{ROW_SEED, OP_PUSH, 8'd0, '1, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd3, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_POP, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_SEED, OP_PUSH, 8'd0, 64'h8000_0000_0000_0000, 1'b0,
                         STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd254, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});
        plan.push_back('{ROW_CMD, OP_PUSH, 8'd0, 64'd0, 1'b0, STAT_OK, 8'd0, 8'd0, 16'd0});

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_SEED) begin
                load_seed(plan[i].seed);
            end else begin
                issue_cmd(plan[i].op, plan[i].nd, r);
                if (plan[i].typed) begin
                    r.status = plan[i].st;
                    r.popped = plan[i].popped;
                    r.head = plan[i].head;
                    r.tag = plan[i].tag;
                end
                pending_results.push_back(r);
            end
        end

        // ---- random phases ----
        // Each phase reloads the seed (random or an extreme) and alternates between
        // push-heavy (deep stacks) and pop-heavy (frequent empty pops) traffic.
        // Most pushes use a node not currently on the stack so the list stays sane;
        // the rest is noise: null pushes, re-pushes of live nodes, random ops.
        for (int p = 0; p < 6; p++) begin
            case (p)
                1:       seed_v = '1;
                3:       seed_v = 64'd1;
                5:       seed_v = '0;
                default: seed_v = {$urandom, $urandom};
            endcase
            load_seed(seed_v);
            push_pct = (p % 2 == 0) ? 65 : 40;
            idle_on = (p != 2);   // phase 2 runs back to back
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 88) begin
                    if ($urandom_range(99) < push_pct) begin
                        op = OP_PUSH;
                        tries = 0;
                        do begin
                            nd = NODE_W'($urandom_range(NODE_COUNT - 1, 1));
                            tries++;
                        end while (on_stack[nd] && tries < 8);
                    end else begin
                        op = OP_POP;
                        nd = NODE_W'($urandom_range(NODE_COUNT - 1));
                    end
                end else begin
                    op = 1'($urandom_range(1));
                    nd = ($urandom_range(3) == 0) ? '0
                         : NODE_W'($urandom_range(NODE_COUNT - 1));
                end
                issue_cmd(op, nd, r);
                pending_results.push_back(r);
            end
        end
        idle_on = 1'b1;

        drain_results();
        $display("Ran %0d commands: %0d pushes, %0d pops, %0d null pushes, %0d empty pops",
                 n_push_ok + n_pop_ok + n_null + n_empty, n_push_ok, n_pop_ok, n_null, n_empty);
        $display("%0d seed loads, %0d results compared, %0d mismatches",
                 n_seed, n_checked, mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
